/* src/sbcm_pkg.sv */
// ----------------------------------------------------------------------------
// sbcm_pkg
// Shared types and constants for the stream block continuity monitor.
// ----------------------------------------------------------------------------
package sbcm_pkg;

  localparam int unsigned CountW = 64;
  localparam int unsigned TotalW = 32;
  localparam int unsigned NumTallies = 8;

  typedef logic [CountW-1:0] count_t;

  // Position of each counter in the tally bank, in result order
  typedef enum logic [2:0] {
    TallyBlocks       = 3'd0,
    TallySamples      = 3'd1,
    TallySeqGaps      = 3'd2,
    TallyIdxGaps      = 3'd3,
    TallyBlocksLost   = 3'd4,
    TallySamplesLost  = 3'd5,
    TallyRegress      = 3'd6,
    TallyEstimated    = 3'd7
  } tally_idx_e;

  typedef struct packed {
    logic [CountW-1:0]        block_sequence;
    logic [CountW-1:0]        first_index;
    logic [TotalW-1:0]        sample_total;
    logic signed [CountW-1:0] stamp_ns;
    logic                     stamp_estimated;
  } sbcm_in_t;

  typedef struct packed {
    logic         rejected;
    logic         sequence_gap;
    logic         index_gap;
    logic         time_went_back;
    count_t       blocks_seen;
    count_t       samples_seen;
    count_t       sequence_gap_count;
    count_t       index_gap_count;
    count_t       blocks_lost;
    count_t       samples_lost;
    count_t       regression_count;
    count_t       estimated_count;
  } sbcm_out_t;

endpackage

/* src/stream_block_continuity_monitor.sv */
// ----------------------------------------------------------------------------
// stream_block_continuity_monitor
// Checks sample-block headers for sequence, index and timestamp continuity
// and keeps running event and loss counters.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-----------------------------
//  in      | in  | in_valid_i / in_ready_o   | in_i  (sbcm_pkg::sbcm_in_t)
//  out     | out | out_valid_o / out_ready_i | out_o (sbcm_pkg::sbcm_out_t)
//
// One item per cycle sustained while the output is not stalled; an accepted
// item passes through the input register, then the result register.
// The cursor and tally registers update at the same edge the result register
// loads, so the next item in the input register sees the updated state.
// A stall on the output holds both stages; the input register still takes an
// item while only the result register is full.
// Reset clears all cursors and counters to zero.
// ----------------------------------------------------------------------------
module stream_block_continuity_monitor (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sbcm_pkg::sbcm_in_t   in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sbcm_pkg::sbcm_out_t  out_o
);

  localparam int unsigned W = sbcm_pkg::CountW;

  // Input stage
  logic               s1_valid_q;
  sbcm_pkg::sbcm_in_t s1_data_q;

  // Result stage
  logic                out_valid_q;
  sbcm_pkg::sbcm_out_t out_data_q;

  // Monitor state
  sbcm_pkg::count_t next_seq_q, next_seq_d;
  sbcm_pkg::count_t next_idx_q, next_idx_d;
  logic [W-1:0]     prev_stamp_q, prev_stamp_d;
  logic             seen_any_q, seen_any_d;
  sbcm_pkg::count_t tallies_q [sbcm_pkg::NumTallies];
  sbcm_pkg::count_t tallies_d [sbcm_pkg::NumTallies];

  logic advance;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_i;
    end
  end

  // Header evaluation
  logic [W:0]       end_index;
  logic             rej;
  logic             sgap, igap, back;
  logic [W+1:0]     blost_sum, slost_sum;
  logic [W:0]       samples_sum;
  sbcm_pkg::count_t cnt_ext;
  sbcm_pkg::sbcm_out_t result;

  always_comb begin
    cnt_ext   = {{(W - sbcm_pkg::TotalW){1'b0}}, s1_data_q.sample_total};
    end_index = {1'b0, s1_data_q.first_index} + {1'b0, cnt_ext};
    rej       = (&s1_data_q.block_sequence) || end_index[W];
    sgap      = !rej && (s1_data_q.block_sequence != next_seq_q);
    igap      = !rej && (s1_data_q.first_index != next_idx_q);
    back      = !rej && seen_any_q &&
                ($signed(s1_data_q.stamp_ns) < $signed(prev_stamp_q));

    // Lost total plus forward gap; only used when the gap is forward
    blost_sum = {2'b00, tallies_q[sbcm_pkg::TallyBlocksLost]} +
                {2'b00, s1_data_q.block_sequence} - {2'b00, next_seq_q};
    slost_sum = {2'b00, tallies_q[sbcm_pkg::TallySamplesLost]} +
                {2'b00, s1_data_q.first_index} - {2'b00, next_idx_q};
    samples_sum = {1'b0, tallies_q[sbcm_pkg::TallySamples]} + {1'b0, cnt_ext};

    tallies_d    = tallies_q;
    next_seq_d   = next_seq_q;
    next_idx_d   = next_idx_q;
    prev_stamp_d = prev_stamp_q;
    seen_any_d   = seen_any_q;

    if (!rej) begin
      if (sgap) begin
        tallies_d[sbcm_pkg::TallySeqGaps] = tallies_q[sbcm_pkg::TallySeqGaps] + W'(1);
        if (s1_data_q.block_sequence > next_seq_q) begin
          tallies_d[sbcm_pkg::TallyBlocksLost] =
              (blost_sum[W+1:W] != 2'b00) ? '1 : blost_sum[W-1:0];
        end
      end
      if (igap) begin
        tallies_d[sbcm_pkg::TallyIdxGaps] = tallies_q[sbcm_pkg::TallyIdxGaps] + W'(1);
        if (s1_data_q.first_index > next_idx_q) begin
          tallies_d[sbcm_pkg::TallySamplesLost] =
              (slost_sum[W+1:W] != 2'b00) ? '1 : slost_sum[W-1:0];
        end
      end
      if (back) begin
        tallies_d[sbcm_pkg::TallyRegress] = tallies_q[sbcm_pkg::TallyRegress] + W'(1);
      end
      if (s1_data_q.stamp_estimated) begin
        tallies_d[sbcm_pkg::TallyEstimated] = tallies_q[sbcm_pkg::TallyEstimated] + W'(1);
      end
      tallies_d[sbcm_pkg::TallyBlocks]  = tallies_q[sbcm_pkg::TallyBlocks] + W'(1);
      tallies_d[sbcm_pkg::TallySamples] = samples_sum[W] ? '1 : samples_sum[W-1:0];

      next_seq_d   = s1_data_q.block_sequence + W'(1);
      next_idx_d   = end_index[W-1:0];
      prev_stamp_d = s1_data_q.stamp_ns;
      seen_any_d   = 1'b1;
    end

    result.rejected           = rej;
    result.sequence_gap       = sgap;
    result.index_gap          = igap;
    result.time_went_back     = back;
    result.blocks_seen        = tallies_d[sbcm_pkg::TallyBlocks];
    result.samples_seen       = tallies_d[sbcm_pkg::TallySamples];
    result.sequence_gap_count = tallies_d[sbcm_pkg::TallySeqGaps];
    result.index_gap_count    = tallies_d[sbcm_pkg::TallyIdxGaps];
    result.blocks_lost        = tallies_d[sbcm_pkg::TallyBlocksLost];
    result.samples_lost       = tallies_d[sbcm_pkg::TallySamplesLost];
    result.regression_count   = tallies_d[sbcm_pkg::TallyRegress];
    result.estimated_count    = tallies_d[sbcm_pkg::TallyEstimated];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_seq_q   <= '0;
      next_idx_q   <= '0;
      prev_stamp_q <= '0;
      seen_any_q   <= 1'b0;
      for (int i = 0; i < sbcm_pkg::NumTallies; i++) begin
        tallies_q[i] <= '0;
      end
    end else if (advance) begin
      next_seq_q   <= next_seq_d;
      next_idx_q   <= next_idx_d;
      prev_stamp_q <= prev_stamp_d;
      seen_any_q   <= seen_any_d;
      tallies_q    <= tallies_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

`ifndef SYNTH
  a_reject_no_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && out_data_q.rejected |->
      !out_data_q.sequence_gap && !out_data_q.index_gap && !out_data_q.time_went_back)
    else $error("rejected header reported a continuity flag");

  a_no_blocks_before_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
      !seen_any_q |-> (tallies_q[sbcm_pkg::TallyBlocks] == '0))
    else $error("block count nonzero before any accepted header");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
      !out_valid_q |-> in_ready_o)
    else $error("input stalled while result register is empty");

  a_advance_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
      advance |=> out_valid_q)
    else $error("result register not loaded after advance");
`endif

endmodule

/* sim/stream_block_continuity_monitor_test.sv */
// ----------------------------------------------------------------------------
// stream_block_continuity_monitor_test
// Drives block headers through the continuity monitor and checks every report
// against a table entry or a cycle-free model of its cursors and counters. A
// short table of corner-case headers runs first, then a long run of mostly
// contiguous streams with gaps, regressions, overflow headers and noise.
// ----------------------------------------------------------------------------
module stream_block_continuity_monitor_test;

  localparam sbcm_pkg::count_t AllOnes  = '1;
  localparam sbcm_pkg::count_t StampMin = 64'h8000_0000_0000_0000;
  localparam sbcm_pkg::count_t StampMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int RandomHeaders = 1500;
  localparam int CalmHeaders   = 200;

  typedef struct {
    sbcm_pkg::sbcm_in_t  hdr;
    bit                  typed;
    sbcm_pkg::sbcm_out_t want;
  } table_row_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                hdr_valid = 1'b0;
  logic                hdr_ready;
  sbcm_pkg::sbcm_in_t  hdr_bus = '0;
  logic                report_valid;
  logic                report_ready = 1'b0;
  sbcm_pkg::sbcm_out_t report_bus;

  // model of the monitor state
  sbcm_pkg::count_t want_sequence = '0;
  sbcm_pkg::count_t want_index = '0;
  sbcm_pkg::count_t last_stamp = '0;
  bit               any_accepted = 1'b0;
  sbcm_pkg::count_t tally [sbcm_pkg::NumTallies];

  sbcm_pkg::sbcm_out_t pending_reports [$];
  table_row_t          directed_rows [$];
  bit                  calm_tail = 1'b0;
  int                  fail_count = 0;

  stream_block_continuity_monitor u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hdr_valid),
    .in_ready_o  (hdr_ready),
    .in_i        (hdr_bus),
    .out_valid_o (report_valid),
    .out_ready_i (report_ready),
    .out_o       (report_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  function automatic sbcm_pkg::count_t rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic sbcm_pkg::count_t sat_add(sbcm_pkg::count_t a, sbcm_pkg::count_t b);
    logic [sbcm_pkg::CountW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[sbcm_pkg::CountW] ? AllOnes : sum[sbcm_pkg::CountW-1:0];
  endfunction

  // Advance the cursor/tally model by one header and return its report.
  function automatic sbcm_pkg::sbcm_out_t update_continuity(sbcm_pkg::sbcm_in_t hdr);
    sbcm_pkg::sbcm_out_t       rpt;
    logic [sbcm_pkg::CountW:0] end_index;
    logic                      reject;
    end_index = {1'b0, hdr.first_index} + {33'd0, hdr.sample_total};
    reject = (hdr.block_sequence == AllOnes) || end_index[sbcm_pkg::CountW];
    rpt = '0;
    rpt.rejected = reject;
    if (!reject) begin
      rpt.sequence_gap = hdr.block_sequence != want_sequence;
      rpt.index_gap = hdr.first_index != want_index;
      rpt.time_went_back = any_accepted && ($signed(hdr.stamp_ns) < $signed(last_stamp));
      if (rpt.sequence_gap) begin
        tally[sbcm_pkg::TallySeqGaps] += 1;
        if (hdr.block_sequence > want_sequence) begin
          tally[sbcm_pkg::TallyBlocksLost] = sat_add(tally[sbcm_pkg::TallyBlocksLost],
                                                     hdr.block_sequence - want_sequence);
        end
      end
      if (rpt.index_gap) begin
        tally[sbcm_pkg::TallyIdxGaps] += 1;
        if (hdr.first_index > want_index) begin
          tally[sbcm_pkg::TallySamplesLost] = sat_add(tally[sbcm_pkg::TallySamplesLost],
                                                      hdr.first_index - want_index);
        end
      end
      if (rpt.time_went_back) tally[sbcm_pkg::TallyRegress] += 1;
      if (hdr.stamp_estimated) tally[sbcm_pkg::TallyEstimated] += 1;
      tally[sbcm_pkg::TallyBlocks] += 1;
      tally[sbcm_pkg::TallySamples] = sat_add(tally[sbcm_pkg::TallySamples],
                                              sbcm_pkg::count_t'(hdr.sample_total));
      want_sequence = hdr.block_sequence + 64'd1;
      want_index = end_index[sbcm_pkg::CountW-1:0];
      last_stamp = hdr.stamp_ns;
      any_accepted = 1'b1;
    end
    rpt.blocks_seen        = tally[sbcm_pkg::TallyBlocks];
    rpt.samples_seen       = tally[sbcm_pkg::TallySamples];
    rpt.sequence_gap_count = tally[sbcm_pkg::TallySeqGaps];
    rpt.index_gap_count    = tally[sbcm_pkg::TallyIdxGaps];
    rpt.blocks_lost        = tally[sbcm_pkg::TallyBlocksLost];
    rpt.samples_lost       = tally[sbcm_pkg::TallySamplesLost];
    rpt.regression_count   = tally[sbcm_pkg::TallyRegress];
    rpt.estimated_count    = tally[sbcm_pkg::TallyEstimated];
    return rpt;
  endfunction

  function automatic sbcm_pkg::sbcm_in_t make_header(sbcm_pkg::count_t seq,
                                                     sbcm_pkg::count_t idx,
                                                     logic [sbcm_pkg::TotalW-1:0] cnt,
                                                     sbcm_pkg::count_t stamp, bit est);
    sbcm_pkg::sbcm_in_t hdr;
    hdr.block_sequence  = seq;
    hdr.first_index     = idx;
    hdr.sample_total    = cnt;
    hdr.stamp_ns        = stamp;
    hdr.stamp_estimated = est;
    return hdr;
  endfunction

  // Report with no gap flags and no events, only block and sample totals.
  function automatic sbcm_pkg::sbcm_out_t plain_report(bit rej, sbcm_pkg::count_t blocks,
                                                       sbcm_pkg::count_t samples);
    sbcm_pkg::sbcm_out_t rpt;
    rpt = '0;
    rpt.rejected     = rej;
    rpt.blocks_seen  = blocks;
    rpt.samples_seen = samples;
    return rpt;
  endfunction

  function automatic void add_row(sbcm_pkg::sbcm_in_t hdr, bit typed,
                                  sbcm_pkg::sbcm_out_t want);
    table_row_t row;
    row.hdr = hdr;
    row.typed = typed;
    row.want = want;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Mostly continue the current stream; mix in gaps, regressions, overflow
  // headers and pure noise.
  function automatic sbcm_pkg::sbcm_in_t next_random_header();
    sbcm_pkg::sbcm_in_t hdr;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    hdr.block_sequence  = want_sequence;
    hdr.first_index     = want_index;
    hdr.sample_total    = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 4096);
    hdr.stamp_ns        = last_stamp + sbcm_pkg::count_t'($urandom_range(0, 1000000));
    hdr.stamp_estimated = ($urandom_range(0, 7) == 0);
    // restart the stream once the cursors have run up against the top
    if (want_sequence == AllOnes || want_index > 64'hFFFF_FFFF_0000_0000) begin
      hdr.block_sequence = sbcm_pkg::count_t'($urandom_range(0, 3));
      hdr.first_index    = sbcm_pkg::count_t'($urandom_range(0, 4096));
    end
    if (pick >= 96) begin
      hdr.block_sequence  = rand64();
      hdr.first_index     = rand64();
      hdr.sample_total    = $urandom();
      hdr.stamp_ns        = rand64();
      hdr.stamp_estimated = $urandom_range(0, 1);
    end else if (pick >= 90) begin
      // land one below, on, or one past the top of the index range
      hdr.block_sequence = AllOnes - sbcm_pkg::count_t'($urandom_range(0, 1));
      hdr.first_index = AllOnes - sbcm_pkg::count_t'(hdr.sample_total)
                        + sbcm_pkg::count_t'($urandom_range(0, 2)) - 64'd1;
    end else if (pick >= 84) begin
      hdr.stamp_ns = last_stamp - sbcm_pkg::count_t'($urandom_range(0, 1000));
    end else if (pick >= 72) begin
      hdr.block_sequence = hdr.block_sequence
                           + sbcm_pkg::count_t'($urandom_range(0, 6)) - 64'd3;
      hdr.first_index = hdr.first_index
                        + sbcm_pkg::count_t'($urandom_range(0, 2000)) - 64'd1000;
    end
    return hdr;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_header(sbcm_pkg::sbcm_in_t hdr, bit typed, sbcm_pkg::sbcm_out_t want);
    sbcm_pkg::sbcm_out_t rpt;
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      hdr_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    hdr_valid <= 1'b1;
    hdr_bus <= hdr;
    do @(posedge clk_i); while (!hdr_ready);
    rpt = update_continuity(hdr);
    pending_reports.insert(pending_reports.size(), typed ? want : rpt);
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, sbcm_pkg::count_t want, sbcm_pkg::count_t got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_report(sbcm_pkg::sbcm_out_t got);
    sbcm_pkg::sbcm_out_t want;
    if (pending_reports.size() == 0) begin
      $error("report with no header outstanding");
      fail_count++;
    end else begin
      want = pending_reports.pop_front();
      check_field("rejected", sbcm_pkg::count_t'(want.rejected),
                  sbcm_pkg::count_t'(got.rejected));
      check_field("sequence_gap", sbcm_pkg::count_t'(want.sequence_gap),
                  sbcm_pkg::count_t'(got.sequence_gap));
      check_field("index_gap", sbcm_pkg::count_t'(want.index_gap),
                  sbcm_pkg::count_t'(got.index_gap));
      check_field("time_went_back", sbcm_pkg::count_t'(want.time_went_back),
                  sbcm_pkg::count_t'(got.time_went_back));
      check_field("blocks_seen", want.blocks_seen, got.blocks_seen);
      check_field("samples_seen", want.samples_seen, got.samples_seen);
      check_field("sequence_gap_count", want.sequence_gap_count, got.sequence_gap_count);
      check_field("index_gap_count", want.index_gap_count, got.index_gap_count);
      check_field("blocks_lost", want.blocks_lost, got.blocks_lost);
      check_field("samples_lost", want.samples_lost, got.samples_lost);
      check_field("regression_count", want.regression_count, got.regression_count);
      check_field("estimated_count", want.estimated_count, got.estimated_count);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && report_valid && report_ready) check_report(report_bus);
  end

  // Result side: stall at random, in bursts, but not in the tail.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        report_ready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 2);
        report_ready <= 1'b0;
      end else begin
        report_ready <= 1'b1;
      end
    end
  end

  initial begin
    foreach (tally[t]) tally[t] = '0;

    // rejects straight after reset, then the first block with a negative stamp
    add_row(make_header(AllOnes, 64'd0, 32'd0, 64'd0, 1'b1), 1'b1, plain_report(1'b1, 0, 0));
    add_row(make_header(64'd0, AllOnes, 32'd1, StampMax, 1'b0), 1'b1,
            plain_report(1'b1, 0, 0));
    add_row(make_header(64'd0, 64'd0, 32'd16, StampMin, 1'b0), 1'b1,
            plain_report(1'b0, 64'd1, 64'd16));
    add_row(make_header(64'd1, 64'd16, 32'd16, StampMin + 64'd100, 1'b1), 1'b0, '0);
    add_row(make_header(64'd2, 64'd32, 32'd0, StampMin + 64'd100, 1'b0), 1'b0, '0);
    add_row(make_header(64'd3, 64'd32, 32'd8, StampMin, 1'b0), 1'b0, '0);
    add_row(make_header(64'd10, 64'd40, 32'd8, 64'd0, 1'b1), 1'b0, '0);
    add_row(make_header(64'd5, 64'd48, 32'd8, 64'd10, 1'b0), 1'b0, '0);
    add_row(make_header(64'd6, 64'd1000, 32'd8, 64'd20, 1'b0), 1'b0, '0);
    add_row(make_header(64'd7, 64'd10, 32'd8, 64'd30, 1'b0), 1'b0, '0);
    add_row(make_header(64'd8, 64'd18, 32'hFFFF_FFFF, StampMax, 1'b1), 1'b0, '0);
    // index plus count exactly at the top, then one past it
    add_row(make_header(64'd9, 64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF, 64'd5, 1'b0),
            1'b0, '0);
    add_row(make_header(64'd10, 64'hFFFF_FFFF_0000_0001, 32'hFFFF_FFFF, 64'd6, 1'b0),
            1'b0, '0);
    add_row(make_header(64'd10, AllOnes, 32'd0, 64'd6, 1'b1), 1'b0, '0);
    add_row(make_header(AllOnes - 64'd1, AllOnes, 32'd0, 64'd7, 1'b0), 1'b0, '0);
    add_row(make_header(AllOnes, AllOnes, 32'd0, 64'd8, 1'b0), 1'b0, '0);
    add_row(make_header(64'd0, 64'd0, 32'd0, StampMin, 1'b1), 1'b0, '0);
    // drive both loss totals into saturation
    add_row(make_header(AllOnes - 64'd1, 64'd0, 32'd0, StampMin, 1'b0), 1'b0, '0);
    add_row(make_header(64'd0, 64'hFFFF_FFFF_FFFF_0000, 32'd0, StampMin, 1'b0), 1'b0, '0);
    add_row(make_header(64'd1, 64'd0, 32'd0, 64'd0, 1'b0), 1'b0, '0);
    add_row(make_header(AllOnes, AllOnes, 32'hFFFF_FFFF, StampMin, 1'b1), 1'b0, '0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      send_header(directed_rows[r].hdr, directed_rows[r].typed, directed_rows[r].want);
    end
    for (int n = 0; n < RandomHeaders; n++) begin
      if (n == RandomHeaders - CalmHeaders) calm_tail = 1'b1;
      send_header(next_random_header(), 1'b0, '0);
    end
    hdr_valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
